>>> hdl/lsms_pkg.sv
// ----------------------------------------------------------------------------
// lsms_pkg
// Types and codes shared by the scan-line mode sequencer files.
// ----------------------------------------------------------------------------
package lsms_pkg;

    localparam int CYCLE_W   = 8;
    localparam int LINE_W    = 8;
    localparam int ELAPSED_W = 16;
    localparam int LENGTH_W  = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = LENGTH_W;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_SCAN   = 2'd2,
        MODE_DRAW   = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LCD_ENABLE    = 3'd0,
        REG_HBLANK_LENGTH = 3'd1,
        REG_VBLANK_LENGTH = 3'd2,
        REG_SCAN_LENGTH   = 3'd3,
        REG_DRAW_LENGTH   = 3'd4
    } reg_index_t;

    localparam logic [LENGTH_W-1:0] HBLANK_LENGTH_RESET = 10'd204;
    localparam logic [LENGTH_W-1:0] VBLANK_LENGTH_RESET = 10'd456;
    localparam logic [LENGTH_W-1:0] SCAN_LENGTH_RESET   = 10'd80;
    localparam logic [LENGTH_W-1:0] DRAW_LENGTH_RESET   = 10'd172;

    typedef struct packed {
        logic                lcd_enable;
        logic [LENGTH_W-1:0] hblank_length;
        logic [LENGTH_W-1:0] vblank_length;
        logic [LENGTH_W-1:0] scan_length;
        logic [LENGTH_W-1:0] draw_length;
    } cfg_t;

    typedef struct packed {
        mode_t                mode;
        logic [LINE_W-1:0]    line;
        logic [ELAPSED_W-1:0] elapsed;
    } seq_state_t;

    typedef struct packed {
        mode_t             mode_now;
        logic [LINE_W-1:0] line_now;
        logic              vblank_irq;
        logic              mode_switched;
    } result_t;

endpackage

>>> hdl/lsms_if.sv
// ----------------------------------------------------------------------------
// lsms channel interfaces
// Tick and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsms_tick_if;
    logic                          valid;
    logic                          ready;
    logic [lsms_pkg::CYCLE_W-1:0]  cycle_count;

    modport source (output valid, output cycle_count, input ready);
    modport sink   (input valid, input cycle_count, output ready);
endinterface

interface lsms_result_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode_now;
    logic [lsms_pkg::LINE_W-1:0]   line_now;
    logic                          vblank_irq;
    logic                          mode_switched;

    modport source (output valid, output mode_now, output line_now,
                    output vblank_irq, output mode_switched, input ready);
    modport sink   (input valid, input mode_now, input line_now,
                    input vblank_irq, input mode_switched, output ready);
endinterface

>>> hdl/lsms_step.sv
// ----------------------------------------------------------------------------
// lsms_step
// Next-state logic for one tick: saturating add, duration compare, mode move.
// ----------------------------------------------------------------------------
module lsms_step #(
    parameter int LAST_VISIBLE_LINE = 143,
    parameter int FINAL_LINE        = 154
) (
    input  lsms_pkg::cfg_t                cfg,
    input  lsms_pkg::seq_state_t          cur,
    input  logic [lsms_pkg::CYCLE_W-1:0]  cycle_count,
    output lsms_pkg::seq_state_t          nxt,
    output lsms_pkg::result_t             res
);

    localparam logic [lsms_pkg::LINE_W-1:0] LAST_LINE =
        lsms_pkg::LINE_W'(LAST_VISIBLE_LINE);
    localparam logic [lsms_pkg::LINE_W-1:0] END_LINE =
        lsms_pkg::LINE_W'(FINAL_LINE);
    localparam logic [lsms_pkg::LINE_W-1:0] LINE_ONE = lsms_pkg::LINE_W'(1);

    logic [lsms_pkg::ELAPSED_W:0]     sum;
    logic [lsms_pkg::ELAPSED_W-1:0]   sat;
    logic [lsms_pkg::ELAPSED_W-1:0]   dur;
    logic [lsms_pkg::LENGTH_W-1:0]    len;
    logic                             expired;
    logic                             irq;
    logic [lsms_pkg::LINE_W-1:0]      line_inc;

    always_comb
    begin
        case (cur.mode)
            lsms_pkg::MODE_HBLANK: len = cfg.hblank_length;
            lsms_pkg::MODE_VBLANK: len = cfg.vblank_length;
            lsms_pkg::MODE_SCAN:   len = cfg.scan_length;
            default:               len = cfg.draw_length;
        endcase
    end

    assign sum = {1'b0, cur.elapsed} +
                 {{(lsms_pkg::ELAPSED_W + 1 - lsms_pkg::CYCLE_W){1'b0}}, cycle_count};
    // saturate at the top of the counter
    assign sat = sum[lsms_pkg::ELAPSED_W] ? {lsms_pkg::ELAPSED_W{1'b1}}
                                          : sum[lsms_pkg::ELAPSED_W-1:0];
    assign dur = {{(lsms_pkg::ELAPSED_W - lsms_pkg::LENGTH_W){1'b0}}, len};
    assign expired  = cfg.lcd_enable && (sat >= dur);
    assign line_inc = cur.line + LINE_ONE;

    always_comb
    begin
        nxt = cur;
        irq = 1'b0;
        if (cfg.lcd_enable)
        begin
            nxt.elapsed = expired ? (sat - dur) : sat;
            if (expired)
            begin
                case (cur.mode)
                    lsms_pkg::MODE_HBLANK:
                    begin
                        if (cur.line == LAST_LINE)
                        begin
                            irq      = 1'b1;
                            nxt.mode = lsms_pkg::MODE_VBLANK;
                        end
                        else
                        begin
                            nxt.line = line_inc;
                            nxt.mode = lsms_pkg::MODE_SCAN;
                        end
                    end
                    lsms_pkg::MODE_VBLANK:
                    begin
                        if (cur.line == END_LINE)
                        begin
                            nxt.line = '0;
                            nxt.mode = lsms_pkg::MODE_SCAN;
                        end
                        else
                        begin
                            nxt.line = line_inc;
                        end
                    end
                    lsms_pkg::MODE_SCAN: nxt.mode = lsms_pkg::MODE_DRAW;
                    default:             nxt.mode = lsms_pkg::MODE_HBLANK;
                endcase
            end
        end
    end

    assign res.mode_now      = nxt.mode;
    assign res.line_now      = nxt.line;
    assign res.vblank_irq    = irq;
    assign res.mode_switched = expired;

endmodule

>>> hdl/lcd_scanline_mode_sequencer_core.sv
// ----------------------------------------------------------------------------
// lcd_scanline_mode_sequencer_core
// Scan-line mode timing: adds up the cycle_count of each tick and steps the display
// through object scan, drawing, horizontal blank and vertical blank.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                         | size
//  ---------+-----+-------------------------------------------------+-----
//  tick     | in  | cycle_count                                     | 8
//  result   | out | mode_now, line_now, vblank_irq, mode_switched   | 12
//  cfg      | in  | cfg_we, cfg_index, cfg_data (write only)        | 3+10
//
//  one item per cycle unless stalled; a result shows the cycle after its tick item
//  the mode, line and elapsed registers update in the cycle the item is taken
//  a held result stalls the tick side only while the result register is full
//  and not being taken; no clearing pass, ready follows reset directly
// ----------------------------------------------------------------------------
module lcd_scanline_mode_sequencer_core #(
    parameter int LAST_VISIBLE_LINE = 143,
    parameter int FINAL_LINE        = 154
) (
    input  logic                             clk,
    input  logic                             rst_n,
    lsms_tick_if.sink                        tick,
    lsms_result_if.source                    result,
    input  logic                             cfg_we,
    input  logic [lsms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lsms_pkg::CFG_DATA_W-1:0]  cfg_data
);

    lsms_pkg::cfg_t        cfg_reg;
    lsms_pkg::seq_state_t  state_reg;
    lsms_pkg::seq_state_t  state_next;
    lsms_pkg::result_t     res_next;
    lsms_pkg::result_t     res_reg;
    logic                  out_valid_reg;
    logic                  take;

    lsms_step #(
        .LAST_VISIBLE_LINE (LAST_VISIBLE_LINE),
        .FINAL_LINE        (FINAL_LINE)
    ) u_step (
        .cfg         (cfg_reg),
        .cur         (state_reg),
        .cycle_count (tick.cycle_count),
        .nxt         (state_next),
        .res         (res_next)
    );

    assign tick.ready = !out_valid_reg || result.ready;
    assign take       = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lcd_enable    <= 1'b1;
            cfg_reg.hblank_length <= lsms_pkg::HBLANK_LENGTH_RESET;
            cfg_reg.vblank_length <= lsms_pkg::VBLANK_LENGTH_RESET;
            cfg_reg.scan_length   <= lsms_pkg::SCAN_LENGTH_RESET;
            cfg_reg.draw_length   <= lsms_pkg::DRAW_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lsms_pkg::REG_LCD_ENABLE:    cfg_reg.lcd_enable    <= cfg_data[0];
                lsms_pkg::REG_HBLANK_LENGTH: cfg_reg.hblank_length <= cfg_data;
                lsms_pkg::REG_VBLANK_LENGTH: cfg_reg.vblank_length <= cfg_data;
                lsms_pkg::REG_SCAN_LENGTH:   cfg_reg.scan_length   <= cfg_data;
                lsms_pkg::REG_DRAW_LENGTH:   cfg_reg.draw_length   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode    <= lsms_pkg::MODE_SCAN;
            state_reg.line    <= '0;
            state_reg.elapsed <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg <= state_next;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.mode_now      = res_reg.mode_now;
    assign result.line_now      = res_reg.line_now;
    assign result.vblank_irq    = res_reg.vblank_irq;
    assign result.mode_switched = res_reg.mode_switched;

endmodule

>>> hdl/lsms_checker.sv
// ----------------------------------------------------------------------------
// lsms_checker
// Port-level checks for the scan-line mode sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lsms_checker #(
    parameter int LAST_VISIBLE_LINE = 143
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            tick_valid,
    input logic                            tick_ready,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [1:0]                      mode_now,
    input logic [lsms_pkg::LINE_W-1:0]     line_now,
    input logic                            vblank_irq,
    input logic                            mode_switched
);

    localparam logic [lsms_pkg::LINE_W-1:0] LAST_LINE =
        lsms_pkg::LINE_W'(LAST_VISIBLE_LINE);

    // a taken tick item always shows a result next cycle
    a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> res_valid)
        else $error("accepted tick item produced no result");

    // a stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(mode_now)
            && $stable(line_now) && $stable(vblank_irq) && $stable(mode_switched))
        else $error("result changed while stalled");

    // vblank entry is a switch into vertical blank
    a_irq_mode: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && vblank_irq |->
            mode_switched && (mode_now == lsms_pkg::MODE_VBLANK))
        else $error("vblank irq without switch into vblank");

    // vblank is entered from the last visible line, which is kept
    a_irq_line: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && vblank_irq |-> line_now == LAST_LINE)
        else $error("vblank irq on wrong line");

endmodule

bind lcd_scanline_mode_sequencer_core lsms_checker #(
    .LAST_VISIBLE_LINE (LAST_VISIBLE_LINE)
) u_lsms_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick_valid    (tick.valid),
    .tick_ready    (tick.ready),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .mode_now      (result.mode_now),
    .line_now      (result.line_now),
    .vblank_irq    (result.vblank_irq),
    .mode_switched (result.mode_switched)
);
